### sv/dfmt_pkg.sv
// shared types and constants for the deduplicating move-to-tail fifo
// no dependencies
package dfmt_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int ITEM_WIDTH_DEFAULT = 16;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

   // per-cycle action broadcast to every cell
   typedef struct packed {
      logic pop;
      logic push_new;
      logic push_dup;
   } ctrl_type;

endpackage

### sv/dfmt_cell.sv
// one queue slot: holds an entry, compares it to the pushed value, shifts toward head
// depends on dfmt_pkg
module dfmt_cell #(
   parameter int ITEM_WIDTH = dfmt_pkg::ITEM_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dfmt_pkg::ctrl_type    ctrl,
   input  logic [ITEM_WIDTH-1:0] item,
   input  logic                  prev_occ,
   input  logic                  prev_past,
   input  logic                  next_occ,
   input  logic [ITEM_WIDTH-1:0] next_value,
   output logic                  occ,
   output logic [ITEM_WIDTH-1:0] value,
   output logic                  past
);

   logic                  occ_ff;
   logic                  occ_in;
   logic [ITEM_WIDTH-1:0] value_ff;
   logic [ITEM_WIDTH-1:0] value_in;
   logic                  match;

   assign match = occ_ff && (value_ff == item);
   assign past  = prev_past | match;
   assign occ   = occ_ff;
   assign value = value_ff;

   always_comb begin
      occ_in   = occ_ff;
      value_in = value_ff;
      if (ctrl.pop) begin
         occ_in   = next_occ;
         value_in = next_value;
      end else if (ctrl.push_dup && past && occ_ff) begin
         // close the gap; the last occupied slot takes the value
         value_in = next_occ ? next_value : item;
      end else if (ctrl.push_new && !occ_ff && prev_occ) begin
         occ_in   = 1'b1;
         value_in = item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### sv/dedup_fifo_move_to_tail.sv
// top level of the deduplicating fifo: row of slot cells plus the response register
// depends on dfmt_pkg and dfmt_cell
//
// A queue of DEPTH entries that never holds the same value twice. Each request beat
// is a push or a pop; each produces exactly one response beat carrying the popped
// value, a status code, a duplicate flag and the occupancy after the request. The
// entries live in a row of cells ordered from head (cell 0) to tail; every cell
// compares its entry against the pushed value in parallel, and a pop or a duplicate
// push shifts entries one cell toward the head in the same cycle. A new beat is taken
// every cycle as long as the response side keeps up: the response register is freed
// in the same cycle it is read. The critical path is the match chain that runs through
// all DEPTH cells, followed by the shift select in each cell. There is no clearing pass
// after reset.
module dedup_fifo_move_to_tail #(
   parameter int DEPTH      = dfmt_pkg::DEPTH_DEFAULT,
   parameter int ITEM_WIDTH = dfmt_pkg::ITEM_WIDTH_DEFAULT,
   localparam int CountWidth = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   input  logic [ITEM_WIDTH-1:0] req_item_value,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ITEM_WIDTH-1:0] rsp_pop_value,
   output logic [1:0]            rsp_status,
   output logic                  rsp_was_duplicate,
   output logic [CountWidth-1:0] rsp_occupancy
);

   // cell row wiring
   logic [DEPTH-1:0]      occ;
   logic [DEPTH-1:0]      past;
   logic [ITEM_WIDTH-1:0] value [DEPTH];
   dfmt_pkg::ctrl_type    ctrl;

   // request decode
   logic accept;
   logic is_pop;
   logic is_push;
   logic any_match;
   logic empty;
   logic full;

   // entry count and response register
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [ITEM_WIDTH-1:0] pop_value_ff;
   logic [ITEM_WIDTH-1:0] pop_value_in;
   logic [1:0]            status_ff;
   logic [1:0]            status_in;
   logic                  dup_ff;
   logic                  dup_in;
   logic [CountWidth-1:0] occupancy_ff;

   // response slot is free when empty or being drained this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_pop    = (req_command == dfmt_pkg::CMD_POP);
   assign is_push   = (req_command == dfmt_pkg::CMD_PUSH);

   assign empty     = !occ[0];
   assign full      = occ[DEPTH-1];
   assign any_match = past[DEPTH-1];

   // only one action per beat; a duplicate push is allowed even when full
   assign ctrl.pop      = accept && is_pop && !empty;
   assign ctrl.push_dup = accept && is_push && any_match;
   assign ctrl.push_new = accept && is_push && !any_match && !full;

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                  prev_occ;
      logic                  prev_past;
      logic                  next_occ;
      logic [ITEM_WIDTH-1:0] next_value;

      if (gi == 0) begin : g_first
         assign prev_occ  = 1'b1;
         assign prev_past = 1'b0;
      end else begin : g_mid
         assign prev_occ  = occ[gi-1];
         assign prev_past = past[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
         assign next_occ   = 1'b0;
         assign next_value = '0;
      end else begin : g_inner
         assign next_occ   = occ[gi+1];
         assign next_value = value[gi+1];
      end

      dfmt_cell #(
         .ITEM_WIDTH (ITEM_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .item       (req_item_value),
         .prev_occ   (prev_occ),
         .prev_past  (prev_past),
         .next_occ   (next_occ),
         .next_value (next_value),
         .occ        (occ[gi]),
         .value      (value[gi]),
         .past       (past[gi])
      );
   end

   // next count and response contents
   always_comb begin
      count_in     = count_ff;
      pop_value_in = '0;
      status_in    = dfmt_pkg::STATUS_OK;
      dup_in       = 1'b0;
      if (ctrl.pop) begin
         count_in     = count_ff - CountWidth'(1);
         pop_value_in = value[0];
      end else if (ctrl.push_new) begin
         count_in = count_ff + CountWidth'(1);
      end else if (ctrl.push_dup) begin
         dup_in = 1'b1;
      end else if (is_pop) begin
         status_in = dfmt_pkg::STATUS_POP_EMPTY;
      end else begin
         status_in = dfmt_pkg::STATUS_PUSH_FULL;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded once per accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         pop_value_ff <= pop_value_in;
         status_ff    <= status_in;
         dup_ff       <= dup_in;
         occupancy_ff <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pop_value     = pop_value_ff;
   assign rsp_status        = status_ff;
   assign rsp_was_duplicate = dup_ff;
   assign rsp_occupancy     = occupancy_ff;

endmodule

### tb/dedup_fifo_move_to_tail_tb.sv
// self-checking testbench for the deduplicating move-to-tail fifo
// depends on dfmt_pkg and the dedup_fifo_move_to_tail rtl; nothing else
`timescale 1ns / 1ps

module dedup_fifo_move_to_tail_tb;

   localparam int DEPTH_N      = dfmt_pkg::DEPTH_DEFAULT;
   localparam int ITEM_W       = dfmt_pkg::ITEM_WIDTH_DEFAULT;
   localparam int CNT_W        = $clog2(DEPTH_N + 1);
   localparam int DIR_ROWS     = 25;
   localparam int RANDOM_ITEMS = 550;
   localparam int POOL_SIZE    = 24;
   localparam int HOLD_START   = 400;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;

   // one response beat, field by field
   typedef struct packed {
      logic [ITEM_W-1:0] pop_value;
      logic [1:0]        status;
      logic              was_duplicate;
      logic [CNT_W-1:0]  occupancy;
   } fifo_rsp_type;

   // one directed request; rsp only used when has_rsp is set
   typedef struct packed {
      logic              command;
      logic [ITEM_W-1:0] value;
      logic              has_rsp;
      fifo_rsp_type      rsp;
   } dir_beat_type;

   // receiver stall patterns
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_MOSTLY,
      RX_EVERY_THIRD,
      RX_COIN
   } rx_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_command = dfmt_pkg::CMD_PUSH;
   logic [ITEM_W-1:0] req_item_value = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ITEM_W-1:0] rsp_pop_value;
   logic [1:0]        rsp_status;
   logic              rsp_was_duplicate;
   logic [CNT_W-1:0]  rsp_occupancy;

   // predictor state: queue contents in order, head first
   logic [ITEM_W-1:0] queued_values [$];
   // responses still owed by the block, oldest first
   fifo_rsp_type      pending_rsps [$];
   fifo_rsp_type      rsp_want;
   // values reused by the random part so duplicates and full pushes happen
   logic [ITEM_W-1:0] value_pool [POOL_SIZE];

   int          fail_count = 0;
   int          rsp_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          hold_left = 0;
   int          mode_left = 0;
   rx_mode_type rx_mode = RX_ALWAYS;

   // directed part: empty pop, extremes, duplicate moves, fill to full,
   // new push on full, duplicate push on full (at head and near the tail), pops
   dir_beat_type directed_beats [DIR_ROWS] = '{
      '{dfmt_pkg::CMD_POP,  16'h0000, 1'b1, '{16'h0000, dfmt_pkg::STATUS_POP_EMPTY, 1'b0, 5'd0}},
      '{dfmt_pkg::CMD_PUSH, 16'h0000, 1'b1, '{16'h0000, dfmt_pkg::STATUS_OK,        1'b0, 5'd1}},
      '{dfmt_pkg::CMD_PUSH, 16'hFFFF, 1'b1, '{16'h0000, dfmt_pkg::STATUS_OK,        1'b0, 5'd2}},
      '{dfmt_pkg::CMD_PUSH, 16'h0000, 1'b1, '{16'h0000, dfmt_pkg::STATUS_OK,        1'b1, 5'd2}},
      '{dfmt_pkg::CMD_POP,  16'h0000, 1'b1, '{16'hFFFF, dfmt_pkg::STATUS_OK,        1'b0, 5'd1}},
      '{dfmt_pkg::CMD_PUSH, 16'h8000, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'h7FFF, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'h5555, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'hAAAA, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'h0001, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'h0002, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'h0004, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'h0008, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'h0010, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'h0100, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'h1000, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'h00FF, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'hFF00, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'h1234, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'hFEDC, 1'b0, '0},
      '{dfmt_pkg::CMD_PUSH, 16'h4321, 1'b1, '{16'h0000, dfmt_pkg::STATUS_PUSH_FULL, 1'b0, 5'd16}},
      '{dfmt_pkg::CMD_PUSH, 16'h0000, 1'b1, '{16'h0000, dfmt_pkg::STATUS_OK,        1'b1, 5'd16}},
      '{dfmt_pkg::CMD_PUSH, 16'hFEDC, 1'b1, '{16'h0000, dfmt_pkg::STATUS_OK,        1'b1, 5'd16}},
      '{dfmt_pkg::CMD_POP,  16'hFFFF, 1'b1, '{16'h8000, dfmt_pkg::STATUS_OK,        1'b0, 5'd15}},
      '{dfmt_pkg::CMD_POP,  16'h1111, 1'b0, '0}
   };

   dedup_fifo_move_to_tail dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_item_value    (req_item_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pop_value     (rsp_pop_value),
      .rsp_status        (rsp_status),
      .rsp_was_duplicate (rsp_was_duplicate),
      .rsp_occupancy     (rsp_occupancy)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // apply one request to the predicted queue and return the response it owes
   function automatic fifo_rsp_type predict_dedup_step(input logic command,
                                                       input logic [ITEM_W-1:0] value);
      fifo_rsp_type r;
      int           hit;
      r   = '0;
      hit = -1;
      if (command == dfmt_pkg::CMD_POP) begin
         if (queued_values.size() == 0) begin
            r.status = dfmt_pkg::STATUS_POP_EMPTY;
         end else begin
            r.pop_value = queued_values.pop_front();
         end
      end else begin
         // only occupied entries are searched, head first
         foreach (queued_values[i]) begin
            if (hit < 0 && queued_values[i] == value) hit = i;
         end
         if (hit >= 0) begin
            // old copy leaves, later entries close up, value goes to the tail
            queued_values.delete(hit);
            queued_values.push_back(value);
            r.was_duplicate = 1'b1;
         end else if (queued_values.size() >= DEPTH_N) begin
            r.status = dfmt_pkg::STATUS_PUSH_FULL;
         end else begin
            queued_values.push_back(value);
         end
      end
      r.occupancy = CNT_W'(queued_values.size());
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("rsp beat %0d: %s got 0x%0h expected 0x%0h", rsp_count, what, got, want);
      fail_count++;
   endtask

   // offer one request beat, idling first when the current burst is used up;
   // the expectation is recorded at the edge where the beat is taken
   task automatic send_request(input logic command, input logic [ITEM_W-1:0] value,
                               input logic has_rsp, input fifo_rsp_type typed_rsp);
      fifo_rsp_type predicted;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_command    <= command;
      req_item_value <= value;
      do @(posedge clock); while (!req_ready);
      predicted = predict_dedup_step(command, value);
      pending_rsps.push_back(has_rsp ? typed_rsp : predicted);
   endtask

   // receiver: pattern changes when its random mode counter runs out, plus long hold-offs
   // that let the block back up and drop req_ready while requests keep coming
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (cycle_count == HOLD_START || $urandom_range(0, 2999) == 0) begin
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS:      rsp_ready <= 1'b1;
            RX_MOSTLY:      rsp_ready <= ($urandom_range(0, 9) < 7);
            RX_EVERY_THIRD: rsp_ready <= (cycle_count % 3 == 0);
            default:        rsp_ready <= 1'($urandom_range(0, 1));
         endcase
      end
      if (mode_left == 0) begin
         rx_mode   <= rx_mode_type'($urandom_range(0, 3));
         mode_left <= $urandom_range(16, 96);
      end else begin
         mode_left <= mode_left - 1;
      end
   end

   // response checker: every taken beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("beat with nothing pending, pop_value", rsp_pop_value, 0);
         end else begin
            rsp_want = pending_rsps.pop_front();
            if (rsp_pop_value !== rsp_want.pop_value)
               report_mismatch("pop_value", rsp_pop_value, rsp_want.pop_value);
            if (rsp_status !== rsp_want.status)
               report_mismatch("status", rsp_status, rsp_want.status);
            if (rsp_was_duplicate !== rsp_want.was_duplicate)
               report_mismatch("was_duplicate", rsp_was_duplicate, rsp_want.was_duplicate);
            if (rsp_occupancy !== rsp_want.occupancy)
               report_mismatch("occupancy", rsp_occupancy, rsp_want.occupancy);
         end
         rsp_count++;
      end
   end

   // stimulus and end of run
   initial begin
      int                k;
      int                phase_left;
      int                push_pct;
      logic              command;
      logic [ITEM_W-1:0] value;
      phase_left = 0;
      push_pct   = 80;
      for (k = 0; k < POOL_SIZE; k++) value_pool[k] = ITEM_W'($urandom);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIR_ROWS; k++)
         send_request(directed_beats[k].command, directed_beats[k].value,
                      directed_beats[k].has_rsp, directed_beats[k].rsp);

      // random part: alternate push-heavy and pop-heavy phases so the queue
      // swings between empty and full; most values come from a small pool
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (phase_left == 0) begin
            push_pct   = (push_pct == 80) ? 30 : 80;
            phase_left = $urandom_range(20, 60);
         end
         phase_left--;
         command = ($urandom_range(0, 99) < push_pct) ? dfmt_pkg::CMD_PUSH
                                                      : dfmt_pkg::CMD_POP;
         if ($urandom_range(0, 3) != 0)
            value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            value = ITEM_W'($urandom);
         send_request(command, value, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("dedup_fifo_move_to_tail test passed");
      else
         $display("dedup_fifo_move_to_tail test failed");
      $finish;
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("dedup_fifo_move_to_tail test failed");
      $finish;
   end

endmodule

### dedup_fifo_move_to_tail.f
sv/dfmt_pkg.sv
sv/dfmt_cell.sv
sv/dedup_fifo_move_to_tail.sv
tb/dedup_fifo_move_to_tail_tb.sv
